### src/rggs_pkg.sv
// ----------------------------------------------------------------------------
// rggs_pkg
// Shared types and constants of the gray gradient statistics block.
// ----------------------------------------------------------------------------
package rggs_pkg;

	localparam int CFG_W    = 11;   // configuration register width
	localparam int IDX_W    = 2;    // configuration index width
	localparam int SUM_W    = 28;   // edge sum width
	localparam int SQ_W     = 36;   // edge square sum width
	localparam int WIDE_W   = 64;   // statistics arithmetic width
	localparam int WSUM_W   = 18;   // weighted channel sum width
	localparam int GRAY_SH  = 28;   // reciprocal shift for divide by 1000
	localparam int GRAY_PW  = 37;   // reciprocal product width
	localparam logic [GRAY_PW-1:0] GRAY_K = GRAY_PW'(268436); // ceil(2^28/1000)
	localparam int MEAN_W   = 16;
	localparam int VAR_W    = 22;

	localparam logic [IDX_W-1:0] REG_WIDTH  = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_HEIGHT = IDX_W'(1);

	localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(640);
	localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(480);

	typedef enum logic [3:0] {
		S_IDLE, S_GRAY, S_DIFF, S_SCALE, S_ROOT, S_ACC,
		S_NQ, S_SS, S_Q1, S_R1, S_T, S_MEAN, S_OUT
	} state_t;

	// operation of the shared multiply/divide unit
	typedef enum logic [2:0] {
		MD_NQ, MD_SS, MD_Q1, MD_R1, MD_T, MD_MEAN
	} md_sel_t;

	typedef struct packed {
		logic    accept;
		logic    ld_gray;
		logic    ld_diff;
		logic    ld_scale;
		logic    root_step;
		logic    ld_acc;
		logic    md_start;
		md_sel_t md_sel;
		logic    ld_out;
	} ctl_t;

	typedef struct packed {
		logic last;
		logic root_last;
		logic md_done;
	} st_t;

endpackage

### src/rggs_if.sv
// ----------------------------------------------------------------------------
// rggs_if
// Pixel and result channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rggs_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source(output valid, red, green, blue, input ready);
	modport sink(input valid, red, green, blue, output ready);
endinterface

interface rggs_res_if;
	logic        valid;
	logic        ready;
	logic [7:0]  edge_value;
	logic        frame_done;
	logic [15:0] mean_scaled;
	logic [21:0] variance_scaled;

	modport source(output valid, edge_value, frame_done, mean_scaled, variance_scaled,
		input ready);
	modport sink(input valid, edge_value, frame_done, mean_scaled, variance_scaled,
		output ready);
endinterface

### src/rgb_gray_gradient_stats_top.sv
// ----------------------------------------------------------------------------
// rgb_gray_gradient_stats_top
// RGB pixels to gray gradient magnitude with per-frame mean and variance.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order on the pixel channel; each yields one result
// item with the saturated gradient magnitude times twenty. The frame's last
// pixel also carries mean and population variance of the edge values, both
// times 256 and truncated. Each pixel passes the gray, difference and scale
// steps, the eight-step bit-serial square root and accumulation before its
// result is loaded; loading waits while the result register stays occupied.
// The last pixel of a frame adds two multiplies and four divides in the
// shared shift-add/restoring unit, whose operand width MB is the larger of
// the frame-size product width and 28. A new pixel is taken while the
// previous result still waits.
// Writing image_width or image_height restarts the frame; the line store
// keeps its contents and needs no clearing pass.
// ----------------------------------------------------------------------------
module rgb_gray_gradient_stats_top #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	rggs_pix_if.sink                   pixel,
	rggs_res_if.source                 result,
	input  logic                       cfg_we,
	input  logic [rggs_pkg::IDX_W-1:0] cfg_index,
	input  logic [rggs_pkg::CFG_W-1:0] cfg_data
);
	import rggs_pkg::*;

	// frame-size product width, or the sum width if larger, sets the shared unit's operand width
	localparam int NB = $clog2(MAX_WIDTH + 1) + $clog2(MAX_HEIGHT + 1);
	localparam int MB = (NB > SUM_W) ? NB : SUM_W;

	ctl_t ctl;
	st_t  st;

	rggs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel.valid),
		.in_ready  (pixel.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.st        (st),
		.ctl       (ctl)
	);

	rggs_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MB         (MB)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.st              (st),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.red             (pixel.red),
		.green           (pixel.green),
		.blue            (pixel.blue),
		.edge_value      (result.edge_value),
		.frame_done      (result.frame_done),
		.mean_scaled     (result.mean_scaled),
		.variance_scaled (result.variance_scaled)
	);

endmodule

### src/rggs_ram.sv
// ----------------------------------------------------------------------------
// rggs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rggs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### src/rggs_muldiv.sv
// ----------------------------------------------------------------------------
// rggs_muldiv
// Shared iterative unit: shift-add multiply or restoring divide, one bit
// per cycle.
// ----------------------------------------------------------------------------
module rggs_muldiv #(
	parameter int MB = 28
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       is_div,
	input  logic [rggs_pkg::WIDE_W-1:0] a,
	input  logic [MB-1:0]              b,
	output logic                       done,
	output logic [rggs_pkg::WIDE_W-1:0] res,
	output logic [MB-1:0]              rem
);
	import rggs_pkg::*;

	localparam int CNTW = $clog2(WIDE_W + 1);

	logic              busy_q, done_q, is_div_q;
	logic [CNTW-1:0]   cnt_q;
	logic [WIDE_W-1:0] acc_q, mc_q;
	logic [MB-1:0]     mb_q;
	logic [MB-1:0]     rem_q;
	logic [MB:0]       trial;
	logic              fits;

	assign trial = {rem_q, mc_q[WIDE_W-1]};
	assign fits  = trial >= {1'b0, mb_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == CNTW'(1));
			if (start && !busy_q && !done_q) begin
				busy_q <= 1'b1;
			end else if (busy_q && (cnt_q == CNTW'(1))) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q && !done_q) begin
			is_div_q <= is_div;
			cnt_q    <= is_div ? CNTW'(WIDE_W) : CNTW'(MB);
			mc_q     <= a;
			mb_q     <= b;
			acc_q    <= '0;
			rem_q    <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNTW'(1);
			mc_q  <= mc_q << 1;
			if (is_div_q) begin
				// shift in the next dividend bit, subtract where it fits
				if (fits) begin
					rem_q <= MB'(trial - {1'b0, mb_q});
				end else begin
					rem_q <= trial[MB-1:0];
				end
				acc_q <= {acc_q[WIDE_W-2:0], fits};
			end else begin
				if (mb_q[0]) begin
					acc_q <= acc_q + mc_q;
				end
				mb_q <= mb_q >> 1;
			end
		end
	end

	assign done = done_q;
	assign res  = acc_q;
	assign rem  = rem_q;

endmodule

### src/rggs_datapath.sv
// ----------------------------------------------------------------------------
// rggs_datapath
// Gray conversion, line store, gradient root, sums and frame statistics.
// ----------------------------------------------------------------------------
module rggs_datapath #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MB         = 28
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rggs_pkg::ctl_t             ctl,
	output rggs_pkg::st_t              st,
	input  logic                       cfg_we,
	input  logic [rggs_pkg::IDX_W-1:0] cfg_index,
	input  logic [rggs_pkg::CFG_W-1:0] cfg_data,
	input  logic [7:0]                 red,
	input  logic [7:0]                 green,
	input  logic [7:0]                 blue,
	output logic [7:0]                 edge_value,
	output logic                       frame_done,
	output logic [15:0]                mean_scaled,
	output logic [21:0]                variance_scaled
);
	import rggs_pkg::*;

	localparam int WB   = $clog2(MAX_WIDTH + 1);
	localparam int HB   = $clog2(MAX_HEIGHT + 1);
	localparam int NB   = WB + HB;
	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RW   = $clog2(MAX_HEIGHT);
	localparam int WCMP = (CFG_W > WB) ? CFG_W : WB;
	localparam int HCMP = (CFG_W > HB) ? CFG_W : HB;

	logic [CFG_W-1:0]   width_q, height_q;
	logic [WB-1:0]      w_eff;
	logic [HB-1:0]      h_eff;
	logic [NB-1:0]      n;
	logic [CW-1:0]      col_q;
	logic [RW-1:0]      row_q;
	logic [7:0]         left_q, up_q, gray_q, ram_rdata;
	logic [WSUM_W-1:0]  wsum_q;
	logic [GRAY_PW-1:0] gray_prod;
	logic [7:0]         adx, ady;
	logic [16:0]        ssum_q;
	logic [25:0]        scaled;
	logic               sat_q;
	logic [15:0]        tr_q;
	logic [7:0]         e_q, trial_e, edge_now;
	logic               border;
	logic [2:0]         bit_q;
	logic [SUM_W-1:0]   sum_q;
	logic [SQ_W-1:0]    sq_q;
	logic [7:0]         edge_q;
	logic               last_q, col_last;
	logic [WIDE_W-1:0]  p_q, numer_q, q1_q, t_q;
	logic [MB-1:0]      r1_q;
	logic [MEAN_W-1:0]  mean_q;
	logic [VAR_W-1:0]   var_q;
	logic [WIDE_W-1:0]  md_a, md_res;
	logic [MB-1:0]      md_b, md_rem;
	logic               md_div, md_done;
	logic               restart;

	// clamp the frame size to 1..MAX
	always_comb begin
		if (width_q == '0) begin
			w_eff = WB'(1);
		end else if (WCMP'(width_q) > WCMP'(MAX_WIDTH)) begin
			w_eff = WB'(MAX_WIDTH);
		end else begin
			w_eff = WB'(width_q);
		end
		if (height_q == '0) begin
			h_eff = HB'(1);
		end else if (HCMP'(height_q) > HCMP'(MAX_HEIGHT)) begin
			h_eff = HB'(MAX_HEIGHT);
		end else begin
			h_eff = HB'(height_q);
		end
	end

	assign n        = NB'(w_eff) * NB'(h_eff);
	assign col_last = (WCMP'(col_q) + WCMP'(1)) >= WCMP'(w_eff);
	assign st.last  = col_last && ((HCMP'(row_q) + HCMP'(1)) >= HCMP'(h_eff));
	assign restart  = cfg_we && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			col_q    <= '0;
			row_q    <= '0;
			left_q   <= '0;
			sum_q    <= '0;
			sq_q     <= '0;
		end else begin
			if (cfg_we && (cfg_index == REG_WIDTH)) begin
				width_q <= cfg_data;
			end
			if (cfg_we && (cfg_index == REG_HEIGHT)) begin
				height_q <= cfg_data;
			end
			if (restart) begin
				col_q  <= '0;
				row_q  <= '0;
				left_q <= '0;
				sum_q  <= '0;
				sq_q   <= '0;
			end else begin
				if (ctl.ld_diff) begin
					left_q <= gray_q;
				end
				if (ctl.ld_acc) begin
					sum_q <= sum_q + SUM_W'(edge_now);
					sq_q  <= sq_q + SQ_W'(16'(edge_now) * 16'(edge_now));
					if (st.last) begin
						col_q <= '0;
						row_q <= '0;
					end else if (col_last) begin
						col_q <= '0;
						row_q <= row_q + RW'(1);
					end else begin
						col_q <= col_q + CW'(1);
					end
				end
				// statistics taken: start the next frame's sums
				if (md_done && (ctl.md_sel == MD_MEAN)) begin
					sum_q <= '0;
					sq_q  <= '0;
				end
			end
		end
	end

	rggs_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line (
		.clk   (clk),
		.we    (ctl.ld_diff),
		.waddr (col_q),
		.wdata (gray_q),
		.re    (ctl.accept),
		.raddr (col_q),
		.rdata (ram_rdata)
	);

	assign gray_prod = GRAY_PW'(wsum_q) * GRAY_K;
	assign adx       = (gray_q >= left_q) ? gray_q - left_q : left_q - gray_q;
	assign ady       = (gray_q >= up_q) ? gray_q - up_q : up_q - gray_q;
	assign scaled    = 26'(ssum_q) * 26'd400;
	assign trial_e   = e_q | (8'd1 << bit_q);
	// first row and first column give no gradient
	assign border    = (col_q == '0) || (row_q == '0);
	assign edge_now  = border ? 8'd0 : (sat_q ? 8'hFF : e_q);
	assign st.root_last = (bit_q == 3'd0);

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			wsum_q <= WSUM_W'(red) * WSUM_W'(299) + WSUM_W'(green) * WSUM_W'(587)
				+ WSUM_W'(blue) * WSUM_W'(114);
		end
		if (ctl.ld_gray) begin
			gray_q <= gray_prod[GRAY_SH +: 8];
			up_q   <= ram_rdata;
		end
		if (ctl.ld_diff) begin
			ssum_q <= 17'(16'(adx) * 16'(adx)) + 17'(16'(ady) * 16'(ady));
		end
		if (ctl.ld_scale) begin
			sat_q <= (scaled[25:16] != '0);
			tr_q  <= scaled[15:0];
			e_q   <= '0;
			bit_q <= 3'd7;
		end
		if (ctl.root_step) begin
			if (16'(trial_e) * 16'(trial_e) <= tr_q) begin
				e_q <= trial_e;
			end
			bit_q <= bit_q - 3'd1;
		end
		if (ctl.ld_acc) begin
			edge_q <= edge_now;
			last_q <= st.last;
		end
		if (md_done) begin
			unique case (ctl.md_sel)
				MD_NQ: p_q <= md_res;
				MD_SS: numer_q <= (p_q > md_res) ? p_q - md_res : '0;
				MD_Q1: begin
					q1_q <= md_res;
					r1_q <= md_rem;
				end
				MD_R1: t_q <= (q1_q << 8) + md_res;
				MD_T: var_q <= md_res[VAR_W-1:0];
				MD_MEAN: mean_q <= md_res[MEAN_W-1:0];
				default: ;
			endcase
		end
		if (ctl.ld_out) begin
			edge_value      <= edge_q;
			frame_done      <= last_q;
			mean_scaled     <= last_q ? mean_q : '0;
			variance_scaled <= last_q ? var_q : '0;
		end
	end

	// operand selection for the shared unit
	always_comb begin
		md_div = 1'b1;
		md_a   = numer_q;
		md_b   = MB'(n);
		unique case (ctl.md_sel)
			MD_NQ: begin
				md_div = 1'b0;
				md_a   = WIDE_W'(sq_q);
			end
			MD_SS: begin
				md_div = 1'b0;
				md_a   = WIDE_W'(sum_q);
				md_b   = MB'(sum_q);
			end
			MD_Q1: md_a = numer_q;
			MD_R1: md_a = WIDE_W'(r1_q) << 8;
			MD_T: md_a = t_q;
			MD_MEAN: md_a = WIDE_W'(sum_q) << 8;
			default: ;
		endcase
	end

	rggs_muldiv #(.MB(MB)) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.md_start),
		.is_div (md_div),
		.a      (md_a),
		.b      (md_b),
		.done   (md_done),
		.res    (md_res),
		.rem    (md_rem)
	);

	assign st.md_done = md_done;

endmodule

### src/rggs_ctrl.sv
// ----------------------------------------------------------------------------
// rggs_ctrl
// Sequencer for one pixel and the end-of-frame statistics.
// ----------------------------------------------------------------------------
module rggs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  rggs_pkg::st_t st,
	output rggs_pkg::ctl_t ctl
);
	import rggs_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		ctl.md_sel = MD_NQ;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				ctl.accept = in_valid;
				if (in_valid) begin
					state_d = S_GRAY;
				end
			end
			S_GRAY: begin
				ctl.ld_gray = 1'b1;
				state_d     = S_DIFF;
			end
			S_DIFF: begin
				ctl.ld_diff = 1'b1;
				state_d     = S_SCALE;
			end
			S_SCALE: begin
				ctl.ld_scale = 1'b1;
				state_d      = S_ROOT;
			end
			S_ROOT: begin
				ctl.root_step = 1'b1;
				if (st.root_last) begin
					state_d = S_ACC;
				end
			end
			S_ACC: begin
				ctl.ld_acc = 1'b1;
				state_d    = st.last ? S_NQ : S_OUT;
			end
			S_NQ: begin
				ctl.md_start = 1'b1;
				ctl.md_sel   = MD_NQ;
				if (st.md_done) state_d = S_SS;
			end
			S_SS: begin
				ctl.md_start = 1'b1;
				ctl.md_sel   = MD_SS;
				if (st.md_done) state_d = S_Q1;
			end
			S_Q1: begin
				ctl.md_start = 1'b1;
				ctl.md_sel   = MD_Q1;
				if (st.md_done) state_d = S_R1;
			end
			S_R1: begin
				ctl.md_start = 1'b1;
				ctl.md_sel   = MD_R1;
				if (st.md_done) state_d = S_T;
			end
			S_T: begin
				ctl.md_start = 1'b1;
				ctl.md_sel   = MD_T;
				if (st.md_done) state_d = S_MEAN;
			end
			S_MEAN: begin
				ctl.md_start = 1'b1;
				ctl.md_sel   = MD_MEAN;
				if (st.md_done) state_d = S_OUT;
			end
			S_OUT: begin
				// hold until the result register is free
				if (!out_valid_q || out_ready) begin
					ctl.ld_out = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_valid_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result raised outside the output step");

	a_done_in_stats: assert property (@(posedge clk) disable iff (!arst_n)
		st.md_done |-> (state_q == S_NQ || state_q == S_SS || state_q == S_Q1 ||
			state_q == S_R1 || state_q == S_T || state_q == S_MEAN))
		else $error("arithmetic unit finished outside the statistics sequence");

	a_root_to_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROOT && st.root_last) |=> state_q == S_ACC)
		else $error("root search did not end in accumulation");
`endif

endmodule
